// ===== hdl/rmd_pkg.sv =====
// Shared types, constants and subround tables for the RIPEMD-160 hash core.
`timescale 1ns / 1ps
package rmd_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [4:0][31:0] t_words5;

    localparam int unsigned ROUNDS_FULL = 160;
    localparam int unsigned ROUNDS_LINE = 80;

    localparam t_words5 CHAIN_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                      32'hefcdab89, 32'h67452301};

    localparam logic [31:0] K_L [0:4] = '{32'h00000000, 32'h5a827999, 32'h6ed9eba1,
                                          32'h8f1bbcdc, 32'ha953fd4e};
    localparam logic [31:0] K_R [0:4] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3,
                                          32'h7a6d76e9, 32'h00000000};

    localparam logic [3:0] SEL_L [0:79] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
        4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
        4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
        4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
        4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
        4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
        4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13};

    localparam logic [3:0] SEL_R [0:79] = '{
        4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
        4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
        4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
        4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
        4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
        4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
        4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
        4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
        4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
        4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11};

    localparam logic [3:0] ROT_L [0:79] = '{
        4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
        4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
        4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
        4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
        4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
        4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
        4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
        4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
        4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
        4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6};

    localparam logic [3:0] ROT_R [0:79] = '{
        4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
        4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
        4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
        4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
        4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
        4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
        4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
        4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
        4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
        4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11};

    // Block buffer operations
    typedef enum logic [2:0] {
        BUF_NONE,
        BUF_BYTE,
        BUF_PAD,
        BUF_LEN,
        BUF_CLR_LEN
    } t_buf_op;

    typedef struct packed {
        t_buf_op     op;
        logic [5:0]  pos;
        logic [7:0]  data;
        logic [63:0] len;
    } t_buf_cmd;

endpackage

// ===== hdl/rmd_block_buf.sv =====
// 16-word message block buffer with byte writes, padding, block clearing and length insertion.
`timescale 1ns / 1ps
module rmd_block_buf (
    input  logic              i_clk,
    input  rmd_pkg::t_buf_cmd i_cmd,
    input  logic [3:0]        i_rd_idx,
    output rmd_pkg::t_word    o_rd_data
);
    import rmd_pkg::*;

    t_word r_mem [0:15];

    always_ff @(posedge i_clk) begin
        for (int w = 0; w < 16; w++) begin
            for (int b = 0; b < 4; b++) begin
                unique case (i_cmd.op)
                    BUF_BYTE: begin
                        if (i_cmd.pos == 6'(w * 4 + b)) begin
                            r_mem[w][b*8 +: 8] <= i_cmd.data;
                        end
                    end
                    BUF_PAD: begin
                        // 0x80 at the current position, zeros to the end of the block
                        if (i_cmd.pos == 6'(w * 4 + b)) begin
                            r_mem[w][b*8 +: 8] <= 8'h80;
                        end else if (6'(w * 4 + b) > i_cmd.pos) begin
                            r_mem[w][b*8 +: 8] <= 8'h00;
                        end
                    end
                    BUF_CLR_LEN: begin
                        if (w < 14) begin
                            r_mem[w][b*8 +: 8] <= 8'h00;
                        end
                    end
                    BUF_LEN, BUF_NONE: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (i_cmd.op == BUF_LEN || i_cmd.op == BUF_CLR_LEN) begin
            r_mem[14] <= i_cmd.len[31:0];
            r_mem[15] <= i_cmd.len[63:32];
        end
    end

    assign o_rd_data = r_mem[i_rd_idx];

endmodule

// ===== hdl/rmd_round.sv =====
// Shared subround datapath: one step of either compression line.
`timescale 1ns / 1ps
module rmd_round (
    input  rmd_pkg::t_words5 i_v,
    input  logic [2:0]       i_tpos,
    input  logic [2:0]       i_fn,
    input  rmd_pkg::t_word   i_x,
    input  rmd_pkg::t_word   i_k,
    input  logic [3:0]       i_rot,
    output rmd_pkg::t_words5 o_v
);
    import rmd_pkg::*;

    function automatic logic [2:0] inc5(input logic [2:0] p);
        return (p == 3'd4) ? 3'd0 : 3'(p + 3'd1);
    endfunction

    logic [2:0]  b_idx, c_idx, d_idx, e_idx;
    t_word       f_val, sum;
    logic [63:0] dbl;

    always_comb begin
        b_idx = inc5(i_tpos);
        c_idx = inc5(b_idx);
        d_idx = inc5(c_idx);
        e_idx = inc5(d_idx);

        unique case (i_fn)
            3'd0:    f_val = i_v[b_idx] ^ i_v[c_idx] ^ i_v[d_idx];
            3'd1:    f_val = (i_v[b_idx] & i_v[c_idx]) | (~i_v[b_idx] & i_v[d_idx]);
            3'd2:    f_val = (i_v[b_idx] | ~i_v[c_idx]) ^ i_v[d_idx];
            3'd3:    f_val = (i_v[b_idx] & i_v[d_idx]) | (i_v[c_idx] & ~i_v[d_idx]);
            default: f_val = i_v[b_idx] ^ (i_v[c_idx] | ~i_v[d_idx]);
        endcase

        sum = i_v[i_tpos] + f_val + i_x + i_k;
        // rotate left: upper half of the doubled word shifted
        dbl = {sum, sum} << i_rot;

        o_v = i_v;
        o_v[i_tpos] = dbl[63:32] + i_v[e_idx];
        o_v[c_idx]  = {i_v[c_idx][21:0], i_v[c_idx][31:22]};
    end

endmodule

// ===== hdl/ripemd160_hash_core.sv =====
// RIPEMD-160 hash core: word intake, padding, iterative compression, digest output.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+--------------------------------------
//  s (in)   | slave     | i_s_tvalid/o_s_tready  | tdata: message_word, valid_bytes; tlast
//  m (out)  | master    | o_m_tvalid/i_m_tready  | tdata: digest_word, word_index; tlast
//  cfg      | slave     | i_cfg_valid/o_cfg_ready| i_cfg_data: round_limit
//
// An item is accepted, its valid bytes go into the block buffer one a cycle (paused to
// compress a full block) and a closing step follows. Each block takes n subrounds
// (effective round limit, 1..160): one shared subround unit runs the left line,
// then the right if n > 80. A last item adds padding (plus a second compression
// when the tail is past byte 55) and five output words. Reset is synchronous; the
// output stalls freely on i_m_tready and no new item is taken until the digest is out.
`timescale 1ns / 1ps
module ripemd160_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [31:0] message_word, [34:32] valid_bytes, rest 0
    input  logic        i_s_tlast,   // last_item
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
    output logic        o_m_tlast,   // final_word
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data   // round_limit
);
    import rmd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_APPEND, S_PAD, S_LEN, S_CLRLEN, S_INIT, S_COMP, S_FEED, S_OUT
    } t_state;

    typedef enum logic [1:0] {RET_APPEND, RET_CLEAR, RET_OUT} t_ret;

    t_state      r_state;
    t_ret        r_ret;
    logic [7:0]  r_round_limit;
    t_words5     r_chain, r_lv, r_rv;
    logic [60:0] r_bcnt;
    t_word       r_word;
    logic [2:0]  r_nleft;
    logic        r_last;
    logic [7:0]  r_cnt;
    logic [2:0]  r_tpos;
    logic [2:0]  r_oidx;

    logic [7:0]  n_limit;
    logic        line_r;
    logic [6:0]  step;
    logic [2:0]  rd;
    logic [2:0]  fn;
    t_word       kval;
    logic [3:0]  rot;
    logic [3:0]  sel;
    t_word       xval;
    t_words5     v_in, v_out;
    logic [60:0] n_bcnt;
    t_buf_cmd    buf_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = (r_state == S_OUT);
    assign o_m_tdata   = {5'd0, r_oidx, r_chain[r_oidx]};
    assign o_m_tlast   = (r_oidx == 3'd4);

    always_comb begin
        if (r_round_limit == 8'd0) begin
            n_limit = 8'd1;
        end else if (r_round_limit > 8'(ROUNDS_FULL)) begin
            n_limit = 8'(ROUNDS_FULL);
        end else begin
            n_limit = r_round_limit;
        end
    end

    always_comb begin
        line_r = (r_cnt >= 8'(ROUNDS_LINE));
        step   = line_r ? 7'(r_cnt - 8'(ROUNDS_LINE)) : r_cnt[6:0];
        rd     = step[6:4];
        fn     = line_r ? 3'(3'd4 - rd) : rd;
        kval   = line_r ? K_R[rd] : K_L[rd];
        rot    = line_r ? ROT_R[step] : ROT_L[step];
        sel    = line_r ? SEL_R[step] : SEL_L[step];
        v_in   = line_r ? r_rv : r_lv;
        n_bcnt = r_bcnt + 61'd1;
    end

    always_comb begin
        buf_cmd.op   = BUF_NONE;
        buf_cmd.pos  = r_bcnt[5:0];
        buf_cmd.data = r_word[7:0];
        buf_cmd.len  = {r_bcnt, 3'b000};
        unique case (r_state)
            S_APPEND: if (r_nleft != 3'd0) buf_cmd.op = BUF_BYTE;
            S_PAD:    buf_cmd.op = BUF_PAD;
            S_LEN:    buf_cmd.op = BUF_LEN;
            S_CLRLEN: buf_cmd.op = BUF_CLR_LEN;
            default:  buf_cmd.op = BUF_NONE;
        endcase
    end

    rmd_block_buf u_buf (
        .i_clk     (i_clk),
        .i_cmd     (buf_cmd),
        .i_rd_idx  (sel),
        .o_rd_data (xval)
    );

    rmd_round u_round (
        .i_v    (v_in),
        .i_tpos (r_tpos),
        .i_fn   (fn),
        .i_x    (xval),
        .i_k    (kval),
        .i_rot  (rot),
        .o_v    (v_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ret         <= RET_APPEND;
            r_round_limit <= 8'(ROUNDS_FULL);
            r_chain       <= CHAIN_INIT;
            r_bcnt        <= '0;
            r_nleft       <= '0;
            r_last        <= 1'b0;
            r_cnt         <= '0;
            r_tpos        <= '0;
            r_oidx        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_round_limit <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_word  <= i_s_tdata[31:0];
                        r_nleft <= (i_s_tdata[34:32] > 3'd4) ? 3'd4 : i_s_tdata[34:32];
                        r_last  <= i_s_tlast;
                        r_state <= S_APPEND;
                    end
                end
                S_APPEND: begin
                    if (r_nleft != 3'd0) begin
                        r_bcnt  <= n_bcnt;
                        r_word  <= {8'd0, r_word[31:8]};
                        r_nleft <= r_nleft - 3'd1;
                        // block full: compress, then resume the remaining bytes
                        if (n_bcnt[5:0] == 6'd0) begin
                            r_ret   <= RET_APPEND;
                            r_state <= S_INIT;
                        end
                    end else if (r_last) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PAD: begin
                    // no room for the length: compress this block, then a fresh one
                    if (r_bcnt[5:0] > 6'd55) begin
                        r_ret   <= RET_CLEAR;
                        r_state <= S_INIT;
                    end else begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN, S_CLRLEN: begin
                    r_ret   <= RET_OUT;
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_lv    <= r_chain;
                    r_rv    <= r_chain;
                    r_cnt   <= '0;
                    r_tpos  <= '0;
                    r_state <= S_COMP;
                end
                S_COMP: begin
                    if (line_r) begin
                        r_rv <= v_out;
                    end else begin
                        r_lv <= v_out;
                    end
                    r_cnt  <= r_cnt + 8'd1;
                    r_tpos <= (r_tpos == 3'd0) ? 3'd4 : 3'(r_tpos - 3'd1);
                    if ((r_cnt + 8'd1) >= n_limit) begin
                        r_state <= S_FEED;
                    end
                end
                S_FEED: begin
                    r_chain[0] <= r_chain[1] + r_lv[2] + r_rv[3];
                    r_chain[1] <= r_chain[2] + r_lv[3] + r_rv[4];
                    r_chain[2] <= r_chain[3] + r_lv[4] + r_rv[0];
                    r_chain[3] <= r_chain[4] + r_lv[0] + r_rv[1];
                    r_chain[4] <= r_chain[0] + r_lv[1] + r_rv[2];
                    unique case (r_ret)
                        RET_APPEND: r_state <= S_APPEND;
                        RET_CLEAR:  r_state <= S_CLRLEN;
                        default:    r_state <= S_OUT;
                    endcase
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        if (r_oidx == 3'd4) begin
                            r_oidx  <= '0;
                            r_chain <= CHAIN_INIT;
                            r_bcnt  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the RIPEMD-160 hash core: messages, round-limit sweeps, stalls.
module testbench;

    localparam int CLK_HALF        = 10;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int LONG_HOLD       = 1500;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int FINAL_SETTLE    = 400;

    // Message word order and rotate amounts, one nibble per subround, subround 0 first
    localparam logic [0:79][3:0] MSG_SEL_LEFT = {
        64'h0123456789abcdef, 64'h74d1a6f3c0952eb8, 64'h3ae49f812706db5c,
        64'h19ba08c4d37fe562, 64'h40597c2ae138b6fd};
    localparam logic [0:79][3:0] MSG_SEL_RIGHT = {
        64'h5e7092b4d6f81a3c, 64'h6b370d5aef8c4912, 64'hf5137e69b8c2a04d,
        64'h86413bf05c2d97ae, 64'hcfa4158762de039b};
    localparam logic [0:79][3:0] SHIFT_LEFT = {
        64'hbefc5879bdef6798, 64'h768db97f7cf9b7dc, 64'hbd67e9dfe8d65c75,
        64'hbcefef989e56865c, 64'h9f5b68dc5cdeb856};
    localparam logic [0:79][3:0] SHIFT_RIGHT = {
        64'h899bdff5778beec6, 64'h9df7c89b77c76fdb, 64'h97fb866ecd5edd75,
        64'hf58bee6e69c9c5f8, 64'h85c9c5e68d65fdbb};

    localparam logic [0:4][31:0] ADD_LEFT  = {32'h00000000, 32'h5a827999, 32'h6ed9eba1,
                                              32'h8f1bbcdc, 32'ha953fd4e};
    localparam logic [0:4][31:0] ADD_RIGHT = {32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3,
                                              32'h7a6d76e9, 32'h00000000};
    localparam logic [0:4][31:0] CHAIN_START = {32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                                32'h10325476, 32'hc3d2e1f0};

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } t_msg_item;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        fin;
    } t_digest_item;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data  = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [39:0] m_tdata;
    wire         m_tlast;
    wire         cfg_ready;

    // Predicted hash state
    logic [0:4][31:0] chain       = CHAIN_START;
    logic [7:0]       blk [64]    = '{default: 8'h00};
    logic [60:0]      msg_bytes   = '0;
    logic [7:0]       round_limit = 8'd160;

    t_msg_item    pending_words[$];
    t_digest_item digest_q[$];
    t_msg_item    offer;

    int  queued_cnt   = 0;
    int  accepted_cnt = 0;
    int  errors       = 0;
    int  cycle_cnt    = 0;
    int  tx_idle_pct  = 0;
    int  rx_idle_pct  = 0;
    int  hold_req     = 0;
    int  hold_seen    = 0;
    int  hold_left    = 0;
    bit  s_taken      = 1'b0;

    ripemd160_hash_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] bool_mix(int fn, logic [31:0] x, logic [31:0] y,
                                             logic [31:0] z);
        case (fn)
            0:       return x ^ y ^ z;
            1:       return (x & y) | (~x & z);
            2:       return (x | ~y) ^ z;
            3:       return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction

    // One subround; the roles a..e rotate through the five slots instead of moving data
    function automatic logic [0:4][31:0] line_step(logic [0:4][31:0] v, int step, int fn,
                                                   logic [31:0] x, logic [31:0] k, int s);
        int t, b, c, d, e;
        t = (5 - step % 5) % 5;
        b = (t + 1) % 5;
        c = (t + 2) % 5;
        d = (t + 3) % 5;
        e = (t + 4) % 5;
        v[t] = rotl(v[t] + bool_mix(fn, v[b], v[c], v[d]) + x + k, s) + v[e];
        v[c] = rotl(v[c], 10);
        return v;
    endfunction

    task automatic compress_block();
        logic [0:4][31:0] lft;
        logic [0:4][31:0] rgt;
        logic [31:0]      w [16];
        logic [31:0]      t;
        int               n, i, j, rd;
        for (i = 0; i < 16; i++) begin
            w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        end
        lft = chain;
        rgt = chain;
        // Zero still runs one subround; anything past a full compression saturates
        n = (round_limit == 0) ? 1 : (round_limit > 160) ? 160 : int'(round_limit);
        for (i = 0; i < n; i++) begin
            if (i < 80) begin
                rd  = i / 16;
                lft = line_step(lft, i, rd, w[MSG_SEL_LEFT[i]], ADD_LEFT[rd],
                                SHIFT_LEFT[i]);
            end else begin
                j   = i - 80;
                rd  = j / 16;
                rgt = line_step(rgt, j, 4 - rd, w[MSG_SEL_RIGHT[j]], ADD_RIGHT[rd],
                                SHIFT_RIGHT[j]);
            end
        end
        t        = chain[1] + lft[2] + rgt[3];
        chain[1] = chain[2] + lft[3] + rgt[4];
        chain[2] = chain[3] + lft[4] + rgt[0];
        chain[3] = chain[4] + lft[0] + rgt[1];
        chain[4] = chain[0] + lft[1] + rgt[2];
        chain[0] = t;
    endtask

    task automatic absorb_byte(logic [7:0] b);
        blk[msg_bytes[5:0]] = b;
        msg_bytes = msg_bytes + 61'd1;
        if (msg_bytes[5:0] == 6'd0) compress_block();
    endtask

    task automatic pad_and_close();
        int          pos, p;
        logic [63:0] bits;
        pos  = msg_bytes[5:0];
        bits = {msg_bytes, 3'b000};
        blk[pos] = 8'h80;
        for (p = pos + 1; p < 64; p++) blk[p] = 8'h00;
        // No room for the length field: close this block and pad a fresh one
        if (pos > 55) begin
            compress_block();
            for (p = 0; p < 64; p++) blk[p] = 8'h00;
        end
        for (p = 0; p < 8; p++) blk[56 + p] = bits[8*p +: 8];
        compress_block();
    endtask

    task automatic hash_word(logic [31:0] word, logic [2:0] nbytes, logic last);
        int nv, i;
        nv = (nbytes > 3'd4) ? 4 : int'(nbytes);
        for (i = 0; i < nv; i++) absorb_byte(word[8*i +: 8]);
        if (last) begin
            pad_and_close();
            for (i = 0; i < 5; i++) begin
                digest_q.push_back(t_digest_item'{word: chain[i], index: 3'(i),
                                                  fin: (i == 4)});
            end
            chain     = CHAIN_START;
            msg_bytes = '0;
        end
    endtask

    // Input side: predict each accepted item
    always @(posedge i_clk) begin
        s_taken = i_rst_n && s_tvalid && s_tready;
        if (s_taken) begin
            hash_word(s_tdata[31:0], s_tdata[34:32], s_tlast);
            accepted_cnt++;
        end
    end

    // Output side: check each accepted digest word against the oldest prediction
    always @(posedge i_clk) begin
        t_digest_item exp_d;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected digest item: word %h index %0d last %0b",
                         $realtime, m_tdata[31:0], m_tdata[34:32], m_tlast);
            end else begin
                exp_d = digest_q.pop_front();
                if (m_tdata[31:0] !== exp_d.word || m_tdata[34:32] !== exp_d.index ||
                    m_tlast !== exp_d.fin) begin
                    errors++;
                    $display({"%0t: digest mismatch: expected word %h index %0d last %0b,",
                              " got word %h index %0d last %0b"},
                             $realtime, exp_d.word, exp_d.index, exp_d.fin,
                             m_tdata[31:0], m_tdata[34:32], m_tlast);
                end
            end
        end
    end

    // Sender: advance to the next item only after the current one is taken
    always @(negedge i_clk) begin
        if (!s_tvalid || s_taken) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                offer = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b00000, offer.nbytes, offer.word};
                s_tlast  <= offer.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus long holds on request
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_item(logic [31:0] word, logic [2:0] nbytes, logic last);
        pending_words.push_back(t_msg_item'{word: word, nbytes: nbytes, last: last});
        queued_cnt++;
    endtask

    task automatic wait_idle(int settle);
        while (accepted_cnt != queued_cnt || digest_q.size() != 0) @(negedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_round_limit(logic [7:0] value);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        round_limit = value;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] next_limit(int grp);
        case (grp)
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            3:       return 8'd80;
            4:       return 8'd81;
            5:       return 8'd159;
            6:       return 8'd161;
            7:       return 8'd160;
            default: return ($urandom_range(0, 2) == 0) ? 8'd160 : 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h00000000;
            1:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    // Mostly full words then a last word; now and then a short word mid-message
    task automatic queue_random_message(output int count);
        int         body, r, i;
        logic [2:0] nb;
        @(posedge i_clk);
        r = $urandom_range(0, 99);
        if (r < 70) body = $urandom_range(0, 17);
        else if (r < 92) body = $urandom_range(18, 36);
        else body = $urandom_range(0, 3);
        for (i = 0; i < body; i++) begin
            nb = ($urandom_range(0, 99) < 12) ? 3'($urandom_range(0, 7)) : 3'd4;
            queue_item(pick_word(), nb, 1'b0);
        end
        queue_item(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
        count = body + 1;
    endtask

    initial begin : stimulus
        int ph, grp, got, total, i;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        tx_idle_pct = 22;
        rx_idle_pct = 87;
        set_round_limit(8'd160);

        @(posedge i_clk);
        // Empty message, bytes of the word ignored
        queue_item(32'hffffffff, 3'd0, 1'b1);
        // "abc" with junk in the unused byte
        queue_item(32'hff636261, 3'd3, 1'b1);
        // Short words before the last one, counts above four saturate
        queue_item(32'h5a5a5aa5, 3'd1, 1'b0);
        queue_item(32'h89abcdef, 3'd7, 1'b0);
        queue_item(32'h0f0f0f0f, 3'd5, 1'b0);
        queue_item(32'h12345678, 3'd2, 1'b1);
        queue_item(32'hf0f0f0f0, 3'd6, 1'b1);
        // 56 bytes: padding spills into a second block
        for (i = 0; i < 13; i++) begin
            queue_item((i % 2) ? 32'hffffffff : 32'h00000000, 3'd4, 1'b0);
        end
        queue_item(32'hc0ffee11, 3'd4, 1'b1);

        grp = 0;
        for (ph = 0; ph < 3; ph++) begin
            wait_idle(20);
            case (ph)
                0: begin
                    tx_idle_pct = 22;
                    rx_idle_pct = 87;
                end
                1: begin
                    tx_idle_pct = 87;
                    rx_idle_pct = 22;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            total = 0;
            while (total < ITEMS_PER_PHASE) begin
                wait_idle(20);
                set_round_limit(next_limit(grp));
                @(posedge i_clk);
                // Hold the output long enough that the sender backs up behind it
                if (total == 0 && ph != 1) hold_req++;
                repeat (2) begin
                    queue_random_message(got);
                    total += got;
                end
                grp++;
            end
        end

        wait_idle(0);
        repeat (FINAL_SETTLE) @(posedge i_clk);
        if (errors == 0 && digest_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rmd_pkg.sv
hdl/rmd_block_buf.sv
hdl/rmd_round.sv
hdl/ripemd160_hash_core.sv
bench/testbench.sv
